[design/rfs_pkg.sv]
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types and constants of the roulette fitness selector.
// ----------------------------------------------------------------------------
`default_nettype none

package rfs_pkg;

    // Design constants.
    localparam int POP_MAX  = 256;
    localparam int FIT_BITS = 32;

    // Fixed field widths.
    localparam int IDX_W   = 8;
    localparam int FIT_W   = 32;
    localparam int TOTAL_W = 40;
    localparam int RND_W   = 16;
    localparam int CNT_W   = 9;

    // Derived sizes.
    localparam int CNT_MAX = (POP_MAX < 256) ? POP_MAX : 256;
    localparam int ADDR_W  = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
    localparam int STORE_W = (FIT_BITS < FIT_W) ? FIT_BITS : FIT_W;
    localparam int HALF_W  = TOTAL_W / 2;
    localparam int PROD_W  = RND_W + HALF_W;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MEMBER_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] COUNT_RESET = 9'd64;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_SELECT = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_THR,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [IDX_W-1:0]   member_index;
        logic [FIT_W-1:0]   fitness_value;
        logic [RND_W-1:0]   random_fraction;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0]   selected_index;
        logic [TOTAL_W-1:0] fitness_sum;
        logic [IDX_W-1:0]   best_index;
        logic [FIT_W-1:0]   best_fitness;
    } t_out_res;

endpackage

`default_nettype wire

[design/roulette_fitness_selector_top.sv]
// ----------------------------------------------------------------------------
// roulette_fitness_selector_top
// Fitness-proportional selector over a population held in a fitness RAM.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel either loads one member's Q16.16
// fitness (func = load) or asks for a roulette pick (func = select). Loading
// member 0 opens a new round and clears the running total and the best.
// Every request returns exactly one result on the output channel, carrying
// the picked member (zero for a load), the round total and the best member.
// member_count is set through the APB port; the user must write it only while
// the block is idle, which the block does not enforce. A load passes through
// S_DONE to the output register. A select runs S_MUL_LO, S_MUL_HI and S_THR,
// walks k RAM entries (1 to the clamped member_count) in S_WALK, reading one
// entry per cycle through the single read port, and ends in S_DONE. The 16x40
// threshold product is formed in two passes through one 16x20 multiplier.
// Requests are taken one at a time; the next request is accepted while the
// previous result still waits in the output register. When the receiver
// stalls, a finished result waits in a holding register until the output
// register frees. Reset clears the total, the best and the control state and
// sets member_count to 64; the fitness RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module roulette_fitness_selector_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rfs_pkg::t_in_req              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rfs_pkg::t_out_res             o_out_data
);
    import rfs_pkg::*;

    // Registers.
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_member_count;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [IDX_W-1:0]     r_best_idx, n_best_idx;
    logic [STORE_W-1:0]   r_best_val, n_best_val;
    logic [RND_W-1:0]     r_rnd, n_rnd;
    logic [PROD_W-1:0]    r_prod_lo, n_prod_lo;
    logic [PROD_W-1:0]    r_prod_hi, n_prod_hi;
    logic [TOTAL_W-1:0]   r_thr, n_thr;
    logic [TOTAL_W-1:0]   r_sum, n_sum;
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    t_out_res             r_res, n_res;
    t_out_res             r_out, n_out;
    logic                 r_out_valid, n_out_valid;
    logic [STORE_W-1:0]   r_rd_data;

    logic [STORE_W-1:0]   fit_mem [CNT_MAX];

    // Combinational signals.
    logic                      in_acc;
    logic                      cfg_wr;
    logic [CNT_W-1:0]          eff_count;
    logic [CNT_W-1:0]          last_idx;
    logic [STORE_W-1:0]        fit_masked;
    logic                      load_ok;
    logic                      round_start;
    logic [TOTAL_W-1:0]        base_total;
    logic [IDX_W-1:0]          base_best_idx;
    logic [STORE_W-1:0]        base_best_val;
    logic [TOTAL_W:0]          load_sum;
    logic [TOTAL_W-1:0]        load_total;
    logic [TOTAL_W:0]          walk_raw;
    logic [TOTAL_W-1:0]        walk_sum;
    logic [HALF_W-1:0]         mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic [RND_W+TOTAL_W-1:0]  thr_full;
    logic [IDX_W-1:0]          cnt_inc;
    logic                      mem_we;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member_count <= COUNT_RESET;
        end else if (cfg_wr && (paddr[2] == REG_MEMBER_COUNT)) begin
            r_member_count <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_MEMBER_COUNT) begin
            prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_member_count};
        end else begin
            prdata = '0;
        end
    end

    // Count clamped to the supported range.
    always_comb begin
        if (r_member_count < CNT_W'(2)) begin
            eff_count = CNT_W'(2);
        end else if (r_member_count > CNT_W'(CNT_MAX)) begin
            eff_count = CNT_W'(CNT_MAX);
        end else begin
            eff_count = r_member_count;
        end
    end
    assign last_idx = eff_count - CNT_W'(1);

    // ------------------------------------------------------------------
    // Load arithmetic
    // ------------------------------------------------------------------
    assign in_acc        = i_in_valid && o_in_ready;
    assign fit_masked    = i_in_data.fitness_value[STORE_W-1:0];
    assign load_ok       = {1'b0, i_in_data.member_index} < eff_count;
    assign round_start   = (i_in_data.member_index == '0);
    assign base_total    = round_start ? '0 : r_total;
    assign base_best_idx = round_start ? '0 : r_best_idx;
    assign base_best_val = round_start ? '0 : r_best_val;
    assign load_sum      = {1'b0, base_total} + (TOTAL_W+1)'(fit_masked);
    assign load_total    = load_sum[TOTAL_W] ? '1 : load_sum[TOTAL_W-1:0];

    // ------------------------------------------------------------------
    // Threshold: one 16x20 multiplier used for both halves of the total
    // ------------------------------------------------------------------
    assign mul_b    = (r_state == S_MUL_LO) ? r_total[HALF_W-1:0]
                                            : r_total[TOTAL_W-1:HALF_W];
    assign mul_p    = r_rnd * mul_b;
    assign thr_full = {r_prod_hi, {HALF_W{1'b0}}} + (RND_W+TOTAL_W)'(r_prod_lo);

    // Cumulative walk sum, saturating.
    assign walk_raw = {1'b0, r_sum} + (TOTAL_W+1)'(r_rd_data);
    assign walk_sum = walk_raw[TOTAL_W] ? '1 : walk_raw[TOTAL_W-1:0];
    assign cnt_inc  = r_cnt + IDX_W'(1);
    assign wr_addr  = i_in_data.member_index[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_rnd       = r_rnd;
        n_prod_lo   = r_prod_lo;
        n_prod_hi   = r_prod_hi;
        n_thr       = r_thr;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        rd_addr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.func == FUNC_LOAD) begin
                        if (load_ok) begin
                            mem_we  = 1'b1;
                            n_total = load_total;
                            if (fit_masked > base_best_val) begin
                                n_best_val = fit_masked;
                                n_best_idx = i_in_data.member_index;
                            end else begin
                                n_best_val = base_best_val;
                                n_best_idx = base_best_idx;
                            end
                        end
                        n_res.selected_index = '0;
                        n_res.fitness_sum    = n_total;
                        n_res.best_index     = n_best_idx;
                        n_res.best_fitness   = FIT_W'(n_best_val);
                        n_state = S_DONE;
                    end else begin
                        n_rnd   = i_in_data.random_fraction;
                        n_state = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO: begin
                n_prod_lo = mul_p;
                n_state   = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_prod_hi = mul_p;
                n_state   = S_THR;
            end
            S_THR: begin
                // Issue the read of member 0 while the threshold settles.
                n_thr   = thr_full[RND_W+TOTAL_W-1:RND_W];
                rd_addr = '0;
                n_sum   = '0;
                n_cnt   = '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                // r_rd_data holds the entry of member r_cnt; fetch the next.
                rd_addr = cnt_inc[ADDR_W-1:0];
                n_sum   = walk_sum;
                if ((walk_sum >= r_thr) || ({1'b0, r_cnt} == last_idx)) begin
                    n_res.selected_index = r_cnt;
                    n_res.fitness_sum    = r_total;
                    n_res.best_index     = r_best_idx;
                    n_res.best_fitness   = FIT_W'(r_best_val);
                    n_state = S_DONE;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_best_idx  <= '0;
            r_best_val  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
            r_best_idx  <= n_best_idx;
            r_best_val  <= n_best_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd     <= n_rnd;
        r_prod_lo <= n_prod_lo;
        r_prod_hi <= n_prod_hi;
        r_thr     <= n_thr;
        r_sum     <= n_sum;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // Fitness RAM: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            fit_mem[wr_addr] <= fit_masked;
        end
        r_rd_data <= fit_mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_round_start_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.func == FUNC_LOAD) && (i_in_data.member_index == '0))
        |=> (r_total == TOTAL_W'($past(fit_masked))))
        else $error("round start did not set the total to the loaded fitness");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ({1'b0, r_cnt} < eff_count))
        else $error("roulette walk ran past the member count");

    a_best_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        TOTAL_W'(r_best_val) <= r_total)
        else $error("best fitness exceeds the round total");

    a_done_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_out_valid) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished result did not move to a free output register");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the roulette fitness selector. A queue of requests
// (directed cases, then well-formed load rounds and selections mixed with
// noise) feeds a clocked driver. The monitor predicts every accepted request
// with its own copy of the fitness store, total and best, and compares each
// result field by field. The population size is reprogrammed over APB
// between phases, and in the first four phases both channels idle at random.
// ----------------------------------------------------------------------------

module testbench;
    import rfs_pkg::*;

    localparam int PHASES          = 6;
    localparam int BURST_PHASE     = 3;
    // Longest quiet stretch of a correct run: a full 256-entry walk plus a
    // long receiver stall and a long sender gap, taken many times over.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 300;
    localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;
    localparam logic [FIT_W-1:0] FIT_MASK = FIT_W'((64'd1 << FIT_BITS) - 64'd1);
    localparam logic [APB_ADDR_W-1:0] MEMBER_COUNT_ADDR =
        APB_ADDR_W'(4 * REG_MEMBER_COUNT);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_req               i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_res              o_out_data;

    roulette_fitness_selector_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Phase plan: programmed member_count and number of counted requests.
    logic [CNT_W-1:0] phase_counts [PHASES] = '{9'd0, 9'd7, 9'd1, 9'd511, 9'd64, 9'd2};
    int unsigned      phase_items  [PHASES] = '{40, 60, 30, 280, 50, 20};

    t_in_req     pending_reqs [$];
    t_out_res    expected_results [$];
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned idle_cycles = 0;
    bit          req_taken = 1'b0;

    // Predictor state.
    logic [CNT_W-1:0]   cfg_member_count = COUNT_RESET;
    logic [FIT_W-1:0]   fitness_mem [POP_MAX];
    logic [TOTAL_W-1:0] round_total = '0;
    logic [IDX_W-1:0]   best_member = '0;
    logic [FIT_W-1:0]   best_value = '0;

    // Generator state: which store entries have been written so far.
    int unsigned gen_members = 2;
    int unsigned gen_made = 0;
    int unsigned gen_next = 0;
    int unsigned selects_left = 0;
    bit          gen_written [POP_MAX];

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned effective_members(input logic [CNT_W-1:0] count);
        int unsigned n;
        n = count;
        if (n < 2) n = 2;
        if (n > POP_MAX) n = POP_MAX;
        if (n > 256) n = 256;
        return n;
    endfunction

    function automatic logic [63:0] sat_add_total(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > TOTAL_MAX) ? TOTAL_MAX : s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic predict_request(input t_in_req req);
        int unsigned      n;
        logic [63:0]      threshold;
        logic [63:0]      cum;
        logic [FIT_W-1:0] fit;
        bit               found;
        t_out_res         res;
        n = effective_members(cfg_member_count);
        fit = req.fitness_value & FIT_MASK;
        res = '0;
        if (req.func == FUNC_LOAD) begin
            if (req.member_index < n) begin
                if (req.member_index == 0) begin
                    round_total = '0;
                    best_member = '0;
                    best_value = '0;
                end
                fitness_mem[req.member_index] = fit;
                round_total = TOTAL_W'(sat_add_total(64'(round_total), 64'(fit)));
                if (fit > best_value) begin
                    best_value = fit;
                    best_member = req.member_index;
                end
            end
        end else begin
            threshold = (64'(req.random_fraction) * 64'(round_total)) >> 16;
            res.selected_index = IDX_W'(n - 1);
            cum = '0;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!found) begin
                    cum = sat_add_total(cum, 64'(fitness_mem[i]));
                    if (cum >= threshold) begin
                        res.selected_index = IDX_W'(i);
                        found = 1'b1;
                    end
                end
            end
        end
        res.fitness_sum = round_total;
        res.best_index = best_member;
        res.best_fitness = best_value;
        expected_results.push_back(res);
    endtask

    task automatic check_result(input t_out_res got);
        t_out_res want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %h with no request outstanding", got));
        end else begin
            want = expected_results.pop_front();
            if (got.selected_index !== want.selected_index)
                report_mismatch($sformatf("selected_index got %0d want %0d",
                                          got.selected_index, want.selected_index));
            if (got.fitness_sum !== want.fitness_sum)
                report_mismatch($sformatf("fitness_sum got %h want %h",
                                          got.fitness_sum, want.fitness_sum));
            if (got.best_index !== want.best_index)
                report_mismatch($sformatf("best_index got %0d want %0d",
                                          got.best_index, want.best_index));
            if (got.best_fitness !== want.best_fitness)
                report_mismatch($sformatf("best_fitness got %h want %h",
                                          got.best_fitness, want.best_fitness));
        end
    endtask

    // Monitor: both channels are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_request(i_in_data);
                req_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready)
                check_result(o_out_data);
        end
    end

    // Driver and receiver: inputs change at the falling edge only.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_data <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        req_taken = 1'b0;
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL roulette_fitness_selector_top");
            $finish;
        end
    end

    task automatic write_member_count(input logic [CNT_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MEMBER_COUNT_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cfg_member_count = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DATA_W'(value))
            report_mismatch($sformatf("member_count read %h want %h", readback, value));
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [FIT_W-1:0] pick_fitness();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return FIT_W'($urandom_range(0, 255)) << 16;
            4:       return FIT_W'($urandom_range(0, 15));
            default: return FIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [RND_W-1:0] pick_fraction();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return RND_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Selections are only queued once every entry in use has been written.
    function automatic bit store_ready();
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < gen_members; i++)
            if (!gen_written[i]) ok = 1'b0;
        return ok;
    endfunction

    task automatic push_request(input t_func func, input int unsigned idx,
                                input logic [FIT_W-1:0] fit, input logic [RND_W-1:0] rnd);
        t_in_req req;
        req.func = func;
        req.member_index = IDX_W'(idx);
        req.fitness_value = fit;
        req.random_fraction = rnd;
        pending_reqs.push_back(req);
        if (func == FUNC_SELECT) begin
            gen_made++;
        end else if (idx < gen_members) begin
            gen_written[idx] = 1'b1;
            gen_made++;
        end
    endtask

    // Runs with two members in use.
    task automatic queue_directed();
        push_request(FUNC_LOAD, 0, '0, '1);
        push_request(FUNC_LOAD, 1, '0, '0);
        // A zero total gives a zero threshold, so member 0 wins.
        push_request(FUNC_SELECT, 0, '0, '0);
        push_request(FUNC_SELECT, 255, '1, '1);
        // Loads past the member count are dropped.
        push_request(FUNC_LOAD, 2, 32'h0000_7B00, 16'h1234);
        push_request(FUNC_LOAD, 255, '1, '1);
        // Equal values keep the first member as best.
        push_request(FUNC_LOAD, 0, 32'h0005_0000, '0);
        push_request(FUNC_LOAD, 1, 32'h0005_0000, '0);
        push_request(FUNC_SELECT, 0, '0, 16'h8000);
        push_request(FUNC_SELECT, 0, '0, '1);
        push_request(FUNC_LOAD, 0, '1, 16'hAAAA);
        push_request(FUNC_LOAD, 1, '1, 16'h5555);
        push_request(FUNC_SELECT, 128, 32'hAAAA_AAAA, '1);
        push_request(FUNC_SELECT, 127, 32'h5555_5555, '0);
        push_request(FUNC_LOAD, 0, 32'h0000_0001, '0);
        push_request(FUNC_LOAD, 1, 32'h0000_0002, '0);
        push_request(FUNC_SELECT, 0, '0, 16'hAAAA);
        push_request(FUNC_SELECT, 0, '0, 16'h5555);
        push_request(FUNC_LOAD, 1, 32'h0000_0007, '0);
        push_request(FUNC_SELECT, 0, '0, 16'h0001);
    endtask

    task automatic queue_random_requests(input int unsigned target);
        int unsigned idx;
        while (gen_made < target) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 2) == 0 && store_ready()) begin
                    push_request(FUNC_SELECT, $urandom_range(0, 255), FIT_W'($urandom),
                                 pick_fraction());
                end else begin
                    idx = $urandom_range(0, 255);
                    push_request(FUNC_LOAD, idx, pick_fitness(), RND_W'($urandom));
                    // A stray load of member 0 restarts the round.
                    if (idx == 0) gen_next = 1;
                end
            end else if (gen_next < gen_members) begin
                push_request(FUNC_LOAD, gen_next, pick_fitness(), RND_W'($urandom));
                gen_next++;
                if (gen_next == gen_members) selects_left = $urandom_range(1, 8);
            end else if (selects_left > 0) begin
                push_request(FUNC_SELECT, $urandom_range(0, 255), FIT_W'($urandom),
                             pick_fraction());
                selects_left--;
            end else begin
                gen_next = 0;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            send_idle_pct = (p < 2) ? 32 : (p < 4) ? 57 : 0;
            recv_idle_pct = (p < 2) ? 57 : (p < 4) ? 32 : 0;
            write_member_count(phase_counts[p]);
            gen_members = effective_members(phase_counts[p]);
            gen_made = 0;
            gen_next = 0;
            selects_left = 0;
            if (p == 0) queue_directed();
            if (p == BURST_PHASE) begin
                // A full population at maximum plus a few more loads drives
                // the total into saturation before the selections.
                for (int i = 0; i < gen_members; i++)
                    push_request(FUNC_LOAD, i, '1, RND_W'($urandom));
                repeat (3) push_request(FUNC_LOAD, gen_members - 1, '1, RND_W'($urandom));
                gen_next = gen_members;
                selects_left = 8;
            end
            queue_random_requests(phase_items[p]);
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS roulette_fitness_selector_top");
        else
            $display("FAIL roulette_fitness_selector_top");
        $finish;
    end

endmodule
